[hw/rtl/sols_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sols_pkg
// Shared constants and types for the self-organising linear search table.
// ----------------------------------------------------------------------------
package sols_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int VALUE_W     = 32;
   localparam int HIT_W       = 5;
   localparam int COUNT_W     = 6;

   localparam int RSP_FIELD_W = 1 + HIT_W + HIT_W + 1 + COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic MODE_TRANSPOSE = 1'b0;
   localparam logic MODE_TO_FRONT  = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] key;
      logic               mode;
   } sols_req_type;

   typedef struct packed {
      logic               found;
      logic [HIT_W-1:0]   hit_position;
      logic [HIT_W-1:0]   new_position;
      logic               table_full;
      logic [COUNT_W-1:0] entry_count;
   } sols_res_type;

endpackage
`default_nettype wire

[hw/rtl/sols_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sols_engine
// Table memory and scan sequencer: one compare per cycle against the key,
// followed by a two-write swap on a hit below the head of the table.
// ----------------------------------------------------------------------------
module sols_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire sols_pkg::sols_req_type req,
   output logic                       idle,
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output sols_pkg::sols_res_type     res
);
   import sols_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_SWAP_A = 3'd2;
   localparam logic [2:0] ST_SWAP_B = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic               mode_ff, mode_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]   hit_ff, hit_in;
   logic [IDX_W-1:0]   dst_ff, dst_in;
   logic               found_ff, found_in;
   logic               full_ff, full_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [IDX_W-1:0]   rd_addr;

   logic               match;
   logic               last_entry;
   logic [IDX_W-1:0]   dst_calc;
   logic               table_is_full;

   assign match         = (rd_data_ff == key_ff);
   assign last_entry    = (CNT_W'(cmp_idx_ff) + CNT_W'(1)) == count_ff;
   assign dst_calc      = (mode_ff == MODE_TO_FRONT) ? '0 : cmp_idx_ff - IDX_W'(1);
   assign table_is_full = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      mode_in    = mode_ff;
      cmp_idx_in = cmp_idx_ff;
      hit_in     = hit_ff;
      dst_in     = dst_ff;
      found_in   = found_ff;
      full_in    = full_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = key_ff;
      rd_addr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in     = req.key;
               mode_in    = req.mode;
               cmp_idx_in = '0;
               hit_in     = '0;
               dst_in     = '0;
               found_in   = 1'b0;
               full_in    = 1'b0;
               if (req.cmd == CMD_APPEND) begin
                  state_in = ST_DONE;
                  if (table_is_full) begin
                     full_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     wr_data  = req.key;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // data for cmp_idx_ff arrives now; fetch the next entry alongside
            rd_addr = cmp_idx_ff + IDX_W'(1);
            if (match) begin
               found_in = 1'b1;
               hit_in   = cmp_idx_ff;
               if (cmp_idx_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  dst_in   = dst_calc;
                  rd_addr  = dst_calc;
                  state_in = ST_SWAP_A;
               end
            end else if (last_entry) begin
               state_in = ST_DONE;
            end else begin
               cmp_idx_in = cmp_idx_ff + IDX_W'(1);
            end
         end
         ST_SWAP_A: begin
            // displaced entry drops into the hit slot
            wr_en    = 1'b1;
            wr_addr  = hit_ff;
            wr_data  = rd_data_ff;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            wr_en    = 1'b1;
            wr_addr  = dst_ff;
            wr_data  = key_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      mode_ff    <= mode_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      dst_ff     <= dst_in;
      found_ff   <= found_in;
      full_ff    <= full_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res.found        = found_ff;
      res.hit_position = HIT_W'(hit_ff);
      res.new_position = (found_ff && hit_ff != '0) ? HIT_W'(dst_ff) : HIT_W'(hit_ff);
      res.table_full   = full_ff;
      res.entry_count  = COUNT_W'(count_ff);
   end

endmodule
`default_nettype wire

[hw/rtl/self_organizing_linear_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// self_organizing_linear_search
// Stream wrapper: request and response channels, mode register, result stage.
// ----------------------------------------------------------------------------
// Table of up to TABLE_DEPTH signed 32-bit values. A search compares one
// stored entry per cycle against the key, reading the table memory through
// its registered read port, and swaps the entry up when a hit lies below the
// head of the table. A new request is taken as soon as the sequencer is idle,
// while the previous result may still wait on rsp_.
// reorder_mode (csr_wdata) picks transposition (0) or swap with entry 0 (1);
// write it only while no request is in flight.
module self_organizing_linear_search (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [sols_pkg::VALUE_W-1:0]        req_tdata,  // [31:0] value
   input  wire logic                                req_tuser,  // [0] cmd
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] found, [5:1] hit_position, [10:6] new_position, [11] table_full,
   // [17:12] entry_count, [23:18] zero
   output logic [sols_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic                                csr_wdata   // reorder_mode
);
   import sols_pkg::*;

   logic         mode_ff, mode_in;
   logic         rsp_valid_ff, rsp_valid_in;
   sols_res_type rsp_ff, rsp_in;

   logic         eng_idle;
   logic         eng_res_valid;
   logic         eng_res_ready;
   sols_res_type eng_res;
   sols_req_type eng_req;
   logic         req_take;

   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_wdata : mode_ff;

   assign req_tready = eng_idle;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      eng_req.cmd  = req_tuser;
      eng_req.key  = req_tdata;
      eng_req.mode = mode_ff;
   end

   sols_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .req       (eng_req),
      .idle      (eng_idle),
      .res_valid (eng_res_valid),
      .res_ready (eng_res_ready),
      .res       (eng_res)
   );

   // result stage frees up in the same cycle its transaction completes
   assign eng_res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_res_valid && eng_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TRANSPOSE;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_ff.entry_count, rsp_ff.table_full,
                        rsp_ff.new_position, rsp_ff.hit_position, rsp_ff.found};

   // the sequencer is busy in the cycle after it takes a request
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("sequencer idle right after taking a request");

   // a miss or an append reports no positions
   a_miss_positions: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |->
      (rsp_ff.hit_position == '0 && rsp_ff.new_position == '0))
      else $error("positions reported without a hit");

   // a hit below the head always moves towards the head
   a_hit_moves_up: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found && rsp_ff.hit_position != '0) |->
      (rsp_ff.new_position < rsp_ff.hit_position && !rsp_ff.table_full))
      else $error("hit entry not moved up");

   // table fill never exceeds its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.entry_count <= COUNT_W'(TABLE_DEPTH)))
      else $error("entry count beyond table depth");

endmodule
`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the self-organising linear search table.
// A short scripted sequence fills part of the table and probes hits at the
// front, moves, duplicates and misses in both reorder modes. Random phases
// follow: the table is filled past capacity, then searched mostly for stored
// keys under alternating modes. Every response is compared field by field
// against a scripted value or a shadow table in the bench, with random idling
// on both streams and one long back-pressure hold on the response side.
// ----------------------------------------------------------------------------
module tb;
   import sols_pkg::*;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata = '0;
   logic                  req_tuser = CMD_APPEND;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_wdata = MODE_TRANSPOSE;

   self_organizing_linear_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // shadow of the table, its fill level and the reorder mode
   logic [VALUE_W-1:0] shadow_entries [TABLE_DEPTH];
   int                 shadow_count = 0;
   logic               shadow_mode  = MODE_TRANSPOSE;

   sols_res_type       expected_results [$];
   int                 errors = 0;
   int                 tx_gap_max = 0;
   int                 rx_stall_max = 0;
   int                 n_append = 0, n_refused = 0, n_hit = 0, n_moved = 0, n_miss = 0;
   int                 n_mode_writes = 0;

   typedef struct {
      logic               mode;
      logic               cmd;
      logic [VALUE_W-1:0] value;
      bit                 typed;
      logic               found;
      logic [HIT_W-1:0]   hit;
      logic [HIT_W-1:0]   moved;
      logic               full;
      logic [COUNT_W-1:0] cnt;
   } script_row_type;

   script_row_type script [22];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

   // apply one command to the shadow table and return the response it gives
   function automatic sols_res_type search_table_step(input logic c, input logic [VALUE_W-1:0] v);
      sols_res_type       r;
      logic [VALUE_W-1:0] held;
      int                 hit;
      int                 dst;
      r   = '0;
      hit = -1;
      if (c == CMD_APPEND) begin
         n_append++;
         if (shadow_count < TABLE_DEPTH) begin
            shadow_entries[shadow_count] = v;
            shadow_count++;
         end else begin
            r.table_full = 1'b1;
            n_refused++;
         end
      end else begin
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_entries[i] == v) begin
               hit = i;
               break;
            end
         end
         if (hit < 0) begin
            n_miss++;
         end else begin
            n_hit++;
            dst = hit;
            if (hit > 0) begin
               dst  = (shadow_mode == MODE_TO_FRONT) ? 0 : hit - 1;
               held = shadow_entries[dst];
               shadow_entries[dst] = shadow_entries[hit];
               shadow_entries[hit] = held;
               n_moved++;
            end
            r.found        = 1'b1;
            r.hit_position = HIT_W'(hit);
            r.new_position = HIT_W'(dst);
         end
      end
      r.entry_count = COUNT_W'(shadow_count);
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic check_result(input logic [RSP_DATA_W-1:0] data);
      sols_res_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: response %h with nothing outstanding", $time, data);
         errors++;
      end else begin
         want = expected_results.pop_front();
         compare_field("found",        32'(want.found),        32'(data[0]));
         compare_field("hit_position", 32'(want.hit_position), 32'(data[5:1]));
         compare_field("new_position", 32'(want.new_position), 32'(data[10:6]));
         compare_field("table_full",   32'(want.table_full),   32'(data[11]));
         compare_field("entry_count",  32'(want.entry_count),  32'(data[17:12]));
      end
   endtask

   // offer one command; on acceptance record the response it must give
   task automatic send_command(input logic c, input logic [VALUE_W-1:0] v, input bit typed,
                               input sols_res_type typed_res);
      int           gap;
      sols_res_type predicted;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= v;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = search_table_step(c, v);
      expected_results.push_back(typed ? typed_res : predicted);
   endtask

   // drain, then write the mode register
   task automatic write_mode(input logic m);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid   <= 1'b0;
      shadow_mode = m;
      n_mode_writes++;
   endtask

   function automatic logic [VALUE_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return VALUE_W'($urandom_range(0, 15));  // small pool breeds duplicates
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] stored_key();
      int idx;
      case ($urandom_range(0, 9))
         0:       idx = 0;
         1:       idx = shadow_count - 1;
         default: idx = $urandom_range(0, shadow_count - 1);
      endcase
      return shadow_entries[idx];
   endfunction

   initial begin : rsp_side
      int stall;
      int seen;
      seen = 0;
      while (reset) @(posedge clock);
      forever begin
         if (seen % 64 == 0) rx_stall_max = $urandom_range(0, 1) ? 18 : 0;
         // long hold once, so that the block fills up and stalls its input
         stall = (seen == 500) ? 400 : $urandom_range(0, rx_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         check_result(rsp_tdata);
         seen++;
      end
   end

   initial begin : req_side
      sols_res_type       want;
      logic               c;
      logic [VALUE_W-1:0] v;
      int                 drain;
      int                 roll;

      script = '{
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'h0000_0000, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0},
         '{MODE_TRANSPOSE, CMD_APPEND, 32'h8000_0000, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd1},
         '{MODE_TRANSPOSE, CMD_APPEND, 32'h7FFF_FFFF, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd2},
         '{MODE_TRANSPOSE, CMD_APPEND, 32'h0000_0000, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd3},
         '{MODE_TRANSPOSE, CMD_APPEND, 32'hFFFF_FFFF, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd4},
         '{MODE_TRANSPOSE, CMD_APPEND, 32'h5555_5555, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd5},
         '{MODE_TRANSPOSE, CMD_APPEND, 32'hAAAA_AAAA, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd6},
         '{MODE_TRANSPOSE, CMD_APPEND, 32'h7FFF_FFFF, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd7},
         // hit at the front stays put
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'h8000_0000, 1, 1'b1, 5'd0, 5'd0, 1'b0, 6'd7},
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'h7FFF_FFFF, 1, 1'b1, 5'd1, 5'd0, 1'b0, 6'd7},
         // duplicate key: lowest index wins
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'h7FFF_FFFF, 1, 1'b1, 5'd0, 5'd0, 1'b0, 6'd7},
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'hAAAA_AAAA, 0, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0},
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'h1234_5678, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd7},
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'hFFFF_FFFF, 0, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0},
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'h0000_0001, 0, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0},
         '{MODE_TRANSPOSE, CMD_SEARCH, 32'h0000_0000, 0, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0},
         '{MODE_TO_FRONT,  CMD_APPEND, 32'h0000_0001, 1, 1'b0, 5'd0, 5'd0, 1'b0, 6'd8},
         '{MODE_TO_FRONT,  CMD_SEARCH, 32'h5555_5555, 0, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0},
         '{MODE_TO_FRONT,  CMD_SEARCH, 32'h0000_0001, 0, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0},
         '{MODE_TO_FRONT,  CMD_SEARCH, 32'h0000_0001, 1, 1'b1, 5'd0, 5'd0, 1'b0, 6'd8},
         '{MODE_TO_FRONT,  CMD_SEARCH, 32'h8000_0000, 0, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0},
         '{MODE_TO_FRONT,  CMD_SEARCH, 32'hFFFF_FFFE, 0, 1'b0, 5'd0, 5'd0, 1'b0, 6'd0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(MODE_TRANSPOSE);

      foreach (script[k]) begin
         if (script[k].mode != shadow_mode) write_mode(script[k].mode);
         want.found        = script[k].found;
         want.hit_position = script[k].hit;
         want.new_position = script[k].moved;
         want.table_full   = script[k].full;
         want.entry_count  = script[k].cnt;
         send_command(script[k].cmd, script[k].value, script[k].typed, want);
      end

      // fill past capacity so that refused appends follow
      write_mode(MODE_TRANSPOSE);
      tx_gap_max = 18;
      for (int n = 0; n < 60; n++) begin
         c = ($urandom_range(0, 9) < 7) ? CMD_APPEND : CMD_SEARCH;
         v = (c == CMD_SEARCH && $urandom_range(0, 1)) ? stored_key() : random_word();
         send_command(c, v, 0, '0);
      end

      // search-heavy phases over a full table, alternating the mode
      for (int p = 1; p <= 8; p++) begin
         write_mode((p % 2 == 1) ? MODE_TO_FRONT : MODE_TRANSPOSE);
         tx_gap_max = (p % 3 == 0) ? 0 : 18;
         for (int n = 0; n < 192; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
               c = CMD_SEARCH;
               v = stored_key();
            end else if (roll < 95) begin
               c = CMD_SEARCH;
               v = random_word();
            end else begin
               c = CMD_APPEND;
               v = random_word();
            end
            send_command(c, v, 0, '0);
         end
      end

      req_tvalid <= 1'b0;
      drain = 0;
      while (expected_results.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      if (expected_results.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_results.size());
         errors++;
      end
      repeat (50) @(posedge clock);

      $display("tb: covered %0d appends (%0d refused at full), %0d mode writes",
               n_append, n_refused, n_mode_writes);
      $display("tb: searches gave %0d hits (%0d moved up) and %0d misses, %0d errors",
               n_hit, n_moved, n_miss, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
